// ===== src/arrset_pkg.sv =====
// Shared types and constants for the array set table.
package arrset_pkg;

  // Width of the capacity register and its value after reset
  localparam int unsigned CFG_W = 7;
  localparam logic [CFG_W-1:0] CAP_RESET = 7'd64;

  // Width of one stored value
  localparam int unsigned DATA_W = 32;

  // Command codes; the unused code acts as a query
  typedef enum logic [1:0] {
    CMD_QUERY  = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_DELETE = 2'd2
  } cmd_t;

  // One result item handed from the sequencer to the output register
  typedef struct packed {
    logic       full_error;
    logic [6:0] occupancy;
    logic [5:0] position;
    logic       found;
  } res_t;

endpackage

// ===== src/array_set_table.sv =====
// Array set table: a set of distinct signed 32-bit values, searched linearly.
//
// Usage:
//   s_* carries commands (query, insert, delete) with a value. One command is
//   worked on at a time; s_tready is high while the sequencer is idle.
//   m_* returns one result per command: found flag, found position,
//   occupancy after the command and a full error for a refused insert.
//   cfg_* writes the capacity limit; cfg_ready is always high. Write it only
//   while no command is in flight.
// Timing:
//   One entry is compared per cycle through the registered read port. A command
//   searches the held values in order; a delete that hits then shifts every
//   later entry down by one, keeping their order.
// Reset:
//   rst clears the occupancy, sets the capacity limit to 64 and empties the
//   output register. Stored entries need no clearing.
// Stall:
//   The result waits in the output register; the sequencer takes the next
//   command once its result has a free slot.
module array_set_table #(
  parameter int unsigned DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  // slave stream: [1:0] cmd, [33:2] value, [39:34] zero
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,
  // master stream: [0] found, [6:1] position, [13:7] occupancy,
  // [14] full_error, [15] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,
  // capacity limit write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data
);

  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNTW = $clog2(DEPTH + 1);

  logic [arrset_pkg::CFG_W-1:0]   cap_limit;
  logic                           res_valid;
  logic                           res_ready;
  arrset_pkg::res_t               res;
  arrset_pkg::res_t               res_q;
  logic                           we;
  logic [AW-1:0]                  waddr;
  logic [arrset_pkg::DATA_W-1:0]  wdata;
  logic [AW-1:0]                  raddr;
  logic [arrset_pkg::DATA_W-1:0]  rdata;

  // Capacity register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_limit <= arrset_pkg::CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cap_limit <= cfg_data;
    end
  end

  // Output register: load when empty or being drained
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      res_q <= res;
    end
  end

  assign m_tdata = {1'b0, res_q.full_error, res_q.occupancy, res_q.position, res_q.found};

  arrset_seq #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CNTW  (CNTW)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_cmd    (s_tdata[1:0]),
    .in_value  (s_tdata[33:2]),
    .cap_limit (cap_limit),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .we        (we),
    .waddr     (waddr),
    .wdata     (wdata),
    .raddr     (raddr),
    .rdata     (rdata)
  );

  arrset_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

endmodule

// ===== src/arrset_mem.sv =====
// Entry storage: one write port, one registered read port.
module arrset_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic                            clk,
  input  logic                            we,
  input  logic [AW-1:0]                   waddr,
  input  logic [arrset_pkg::DATA_W-1:0]   wdata,
  input  logic [AW-1:0]                   raddr,
  output logic [arrset_pkg::DATA_W-1:0]   rdata
);

  logic [arrset_pkg::DATA_W-1:0] mem [DEPTH];

  // Write one entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Register the read data
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== src/arrset_seq.sv =====
// Sequencer: linear search with a shared compare, append on insert,
// order-keeping shift on delete.
module arrset_seq #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6,
  parameter int unsigned CNTW  = 7
) (
  input  logic                                clk,
  input  logic                                rst,
  // command in
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_cmd,
  input  logic signed [arrset_pkg::DATA_W-1:0] in_value,
  input  logic [arrset_pkg::CFG_W-1:0]        cap_limit,
  // result out
  output logic                                res_valid,
  input  logic                                res_ready,
  output arrset_pkg::res_t                    res,
  // memory port
  output logic                                we,
  output logic [AW-1:0]                       waddr,
  output logic [arrset_pkg::DATA_W-1:0]       wdata,
  output logic [AW-1:0]                       raddr,
  input  logic [arrset_pkg::DATA_W-1:0]       rdata
);

  localparam int unsigned CMPW = (CNTW > arrset_pkg::CFG_W) ? CNTW : arrset_pkg::CFG_W;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SEARCH = 4'b0010,
    ST_SHIFT  = 4'b0100,
    ST_DONE   = 4'b1000
  } state_t;

  state_t                             state, state_next;
  logic [1:0]                         cmd_q, cmd_q_next;
  logic signed [arrset_pkg::DATA_W-1:0] value_q, value_q_next;
  logic [AW-1:0]                      idx, idx_next;
  logic [AW-1:0]                      pos, pos_next;
  logic [CNTW-1:0]                    count, count_next;
  logic                               found, found_next;
  logic                               full, full_next;

  logic                               hit;
  logic                               last_search;
  logic                               last_shift;
  logic                               room;

  // Shared compare and bound checks
  assign hit         = (count != '0) && (rdata == value_q);
  assign last_search = (CNTW'(idx) + CNTW'(1)) >= count;
  assign last_shift  = (CNTW'(idx) + CNTW'(2)) >= count;
  assign room        = (CMPW'(count) < CMPW'(cap_limit)) && (count < CNTW'(DEPTH));

  assign in_ready  = (state == ST_IDLE);
  assign res_valid = (state == ST_DONE);

  assign res.found      = found;
  assign res.position   = 6'(pos);
  assign res.occupancy  = 7'(count);
  assign res.full_error = full;

  // Next-state and memory control
  always_comb begin
    state_next   = state;
    cmd_q_next   = cmd_q;
    value_q_next = value_q;
    idx_next     = idx;
    pos_next     = pos;
    count_next   = count;
    found_next   = found;
    full_next    = full;
    we           = 1'b0;
    waddr        = AW'(count);
    wdata        = value_q;
    raddr        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd_q_next   = in_cmd;
          value_q_next = in_value;
          idx_next     = '0;
          pos_next     = '0;
          found_next   = 1'b0;
          full_next    = 1'b0;
          state_next   = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        raddr = idx + AW'(1);
        if (hit) begin
          found_next = 1'b1;
          pos_next   = idx;
          if (cmd_q == arrset_pkg::CMD_DELETE) begin
            if (last_search) begin
              count_next = count - CNTW'(1);
              state_next = ST_DONE;
            end else begin
              state_next = ST_SHIFT;
            end
          end else begin
            state_next = ST_DONE;
          end
        end else if (last_search) begin
          if (cmd_q == arrset_pkg::CMD_INSERT) begin
            if (room) begin
              we         = 1'b1;
              count_next = count + CNTW'(1);
            end else begin
              full_next  = 1'b1;
            end
          end
          state_next = ST_DONE;
        end else begin
          idx_next = idx + AW'(1);
        end
      end
      ST_SHIFT: begin
        // move the entry above down by one
        raddr    = idx + AW'(2);
        we       = 1'b1;
        waddr    = idx;
        wdata    = rdata;
        idx_next = idx + AW'(1);
        if (last_shift) begin
          count_next = count - CNTW'(1);
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // Work registers
  always_ff @(posedge clk) begin
    cmd_q   <= cmd_q_next;
    value_q <= value_q_next;
    idx     <= idx_next;
    pos     <= pos_next;
    found   <= found_next;
    full    <= full_next;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNTW'(DEPTH))
    else $error("occupancy above table depth");

  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    we |-> (state == ST_SEARCH || state == ST_SHIFT))
    else $error("memory write outside search or shift");

  a_full_miss: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && full) |-> !found)
    else $error("full error on a value already present");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && count != $past(count)) |->
      (count == CNTW'($past(count) + CNTW'(1)) || count == CNTW'($past(count) - CNTW'(1))))
    else $error("occupancy moved by more than one");
`endif

endmodule

// ===== tb/array_set_table_check.sv =====
// Checker for the array set table: tracks the set, predicts each result and compares.
module array_set_table_check #(
  parameter int unsigned DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [6:0]  cfg_data,
  output int          fail_count,
  output int          pending
);

  // Own copy of the table, its fill level and the capacity register
  logic [arrset_pkg::DATA_W-1:0] set_vals [DEPTH];
  int unsigned                   held;
  logic [arrset_pkg::CFG_W-1:0]  cap_limit;
  arrset_pkg::res_t              awaited_results[$];
  arrset_pkg::res_t              want;
  arrset_pkg::res_t              got;

  initial begin
    fail_count = 0;
    pending    = 0;
    held       = 0;
    cap_limit  = arrset_pkg::CAP_RESET;
  end

  // Search the set for one command, apply it and return what the block should report
  function automatic arrset_pkg::res_t apply_command(logic [1:0] op,
                                                     logic [arrset_pkg::DATA_W-1:0] v);
    arrset_pkg::res_t r;
    int unsigned      idx;
    int unsigned      room;
    bit               hit;
    hit = 1'b0;
    idx = 0;
    for (int unsigned i = 0; i < held; i++) begin
      if (!hit && set_vals[i] == v) begin
        hit = 1'b1;
        idx = i;
      end
    end
    room = (cap_limit < DEPTH) ? cap_limit : DEPTH;
    r.full_error = 1'b0;
    if (op == arrset_pkg::CMD_INSERT && !hit) begin
      if (held < room) begin
        set_vals[held] = v;
        held++;
      end else begin
        r.full_error = 1'b1;
      end
    end else if (op == arrset_pkg::CMD_DELETE && hit) begin
      // close the gap, keeping the order of later entries
      for (int unsigned i = idx; i + 1 < held; i++) begin
        set_vals[i] = set_vals[i + 1];
      end
      held--;
    end
    r.found     = hit;
    r.position  = idx[5:0];
    r.occupancy = held[6:0];
    return r;
  endfunction

  // Watch all three channels; results are matched before new commands are queued
  always @(posedge clk) begin
    if (rst) begin
      held      = 0;
      cap_limit = arrset_pkg::CAP_RESET;
      awaited_results.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata[14:0];
        if (awaited_results.size() == 0) begin
          $display("%0t: result with nothing awaited, actual %h", $time, got);
          fail_count = fail_count + 1;
        end else begin
          want = awaited_results.pop_front();
          if (got.found !== want.found) begin
            $display("%0t: found expected %0d actual %0d", $time, want.found, got.found);
            fail_count = fail_count + 1;
          end
          if (got.position !== want.position) begin
            $display("%0t: position expected %0d actual %0d", $time,
                     want.position, got.position);
            fail_count = fail_count + 1;
          end
          if (got.occupancy !== want.occupancy) begin
            $display("%0t: occupancy expected %0d actual %0d", $time,
                     want.occupancy, got.occupancy);
            fail_count = fail_count + 1;
          end
          if (got.full_error !== want.full_error) begin
            $display("%0t: full_error expected %0d actual %0d", $time,
                     want.full_error, got.full_error);
            fail_count = fail_count + 1;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        cap_limit = cfg_data;
      end
      if (s_tvalid && s_tready) begin
        awaited_results.push_back(apply_command(s_tdata[1:0], s_tdata[33:2]));
      end
    end
    pending <= awaited_results.size();
  end

endmodule

// ===== tb/array_set_table_test.sv =====
// Top of the array set table test: clock, reset, stimulus and verdict.
module array_set_table_test;

  // The spare command code, handled by the block as a query
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic [39:0] s_tdata   = '0;
  logic        m_tready  = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [6:0]  cfg_data  = arrset_pkg::CAP_RESET;
  logic        s_tready;
  logic        m_tvalid;
  logic [15:0] m_tdata;
  logic        cfg_ready;
  int          fail_count;
  int          pending;
  int          stall_left = 0;
  bit          calm       = 1'b0;
  int          pool_size  = 8;

  array_set_table #(.DEPTH(64)) uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  array_set_table_check #(.DEPTH(64)) table_check (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Idle length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Value pool: the extremes first, then scattered distinct values
  function automatic logic [31:0] pool_value(int k);
    case (k)
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return (k * 32'h9e37_79b9) ^ 32'h5a5a_0000;
    endcase
  endfunction

  // Mostly reuse pool values so hits, duplicates and deletes happen often
  function automatic logic [31:0] pick_value();
    if ($urandom_range(0, 99) < 85) return pool_value($urandom_range(0, pool_size - 1));
    return $urandom();
  endfunction

  function automatic logic [1:0] pick_cmd();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return arrset_pkg::CMD_INSERT;
    if (r < 70) return arrset_pkg::CMD_DELETE;
    if (r < 95) return arrset_pkg::CMD_QUERY;
    return CMD_UNUSED;
  endfunction

  // Receiver side: random stalls; no new stall starts during calm stretches
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else if (calm || $urandom_range(0, 99) < 70) begin
      m_tready <= 1'b1;
    end else begin
      m_tready   <= 1'b0;
      stall_left <= idle_len();
    end
  end

  // Offer one command, hold it until transfer, then idle a random while outside calm stretches
  task automatic send_command(logic [1:0] op, logic [31:0] v);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, v, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    gap = calm ? 0 : idle_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Wait until every awaited result has come back
  task automatic wait_idle();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(logic [6:0] cap);
    s_tvalid <= 1'b0;
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(logic [6:0] cap, int pool, int count);
    write_capacity(cap);
    pool_size = pool;
    for (int i = 0; i < count; i++) begin
      calm = (i % 80) < 10;
      send_command(pick_cmd(), pick_value());
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty table, extremes, duplicates, shifts, spare code, full cases
    send_command(arrset_pkg::CMD_QUERY,  32'h8000_0000);
    send_command(arrset_pkg::CMD_DELETE, 32'h0000_0000);
    send_command(arrset_pkg::CMD_INSERT, 32'h8000_0000);
    send_command(arrset_pkg::CMD_INSERT, 32'h7fff_ffff);
    send_command(arrset_pkg::CMD_INSERT, 32'h0000_0000);
    send_command(arrset_pkg::CMD_INSERT, 32'hffff_ffff);
    send_command(arrset_pkg::CMD_INSERT, 32'h7fff_ffff);
    send_command(arrset_pkg::CMD_QUERY,  32'hffff_ffff);
    send_command(arrset_pkg::CMD_QUERY,  32'h1234_5678);
    send_command(arrset_pkg::CMD_DELETE, 32'h0000_0001);
    send_command(arrset_pkg::CMD_DELETE, 32'h8000_0000);
    send_command(arrset_pkg::CMD_QUERY,  32'h7fff_ffff);
    send_command(CMD_UNUSED, 32'h0000_0000);
    send_command(CMD_UNUSED, 32'h5555_5555);
    send_command(arrset_pkg::CMD_DELETE, 32'hffff_ffff);
    write_capacity(7'd2);
    send_command(arrset_pkg::CMD_INSERT, 32'h0000_0005);
    send_command(arrset_pkg::CMD_INSERT, 32'h0000_0000);
    write_capacity(7'd0);
    send_command(arrset_pkg::CMD_INSERT, 32'h0000_0009);
    send_command(arrset_pkg::CMD_DELETE, 32'h7fff_ffff);
    send_command(arrset_pkg::CMD_QUERY,  32'h0000_0000);
    send_command(arrset_pkg::CMD_INSERT, 32'h0000_0009);
    send_command(arrset_pkg::CMD_DELETE, 32'h0000_0000);

    // Random phases: moderate fill, overfill, limit below occupancy, zero, above depth
    run_phase(7'd64,  40,  200);
    run_phase(7'd64,  90,  250);
    run_phase(7'd3,   6,   100);
    run_phase(7'd0,   8,   50);
    run_phase(7'd127, 90,  200);
    run_phase(7'd1,   4,   100);
    run_phase(7'd20,  30,  150);

    s_tvalid <= 1'b0;
    wait_idle();
    repeat (130) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
